// File: hw/rtl/spmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared widths, codes and types of the CSR sparse matrix-vector engine.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int unsigned VECTOR_DEPTH_DEF   = 4096;
  localparam int unsigned ROW_COUNT_BITS_DEF = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned INDEX_W   = 13;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned ROW_NUM_W = 16;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 80;  // 13 + 32 + 32 bits, padded to bytes
  localparam int unsigned OUT_DATA_W = 56;  // 16 + 32 + 1 + 1 bits, padded to bytes

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NONZERO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMPTY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd3;

  typedef struct packed {
    logic              add;    // product goes into the accumulator
    logic              bad;    // column outside the store
    logic              close;  // item ends the row
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] addend;
  } nz_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]     acc;
    logic                 sat;
    logic                 bad;
    logic [DATA_W-1:0]    addend;
    logic [ROW_NUM_W-1:0] row_num;
  } row_close_t;

endpackage : spmv_pkg
`default_nettype wire

// File: hw/rtl/spmv_vec_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmv_vec_mem
// Dense vector store: one write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module spmv_vec_mem
  import spmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VECTOR_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [VECTOR_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : spmv_vec_mem
`default_nettype wire

// File: hw/rtl/spmv_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmv_mac
// Nonzero pipeline: multiply by the vector entry, saturating row accumulate,
// row counter, and hand-off of each closed row.
// ----------------------------------------------------------------------------
module spmv_mac
  import spmv_pkg::*;
#(
  parameter int unsigned ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire nz_item_t          item,
  input  wire logic [DATA_W-1:0] vec_data,
  output logic                   close_pending,
  output logic                   close_valid,
  output row_close_t             close_info
);

  logic                      s1_v_r;
  nz_item_t                  s1_item_r;
  logic                      s2_v_r;
  nz_item_t                  s2_item_r;
  logic signed [ACC_W-1:0]   s2_prod_r;
  logic signed [ACC_W-1:0]   prod_nxt;

  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      sat_r, sat_nxt;
  logic                      bad_r, bad_nxt;
  logic [ROW_COUNT_BITS-1:0] row_ctr_r;

  logic signed [ACC_W:0]     sum_wide;
  logic                      ovf_pos, ovf_neg;

  assign prod_nxt = $signed(s1_item_r.value) * $signed(vec_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= item_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= item;
    s2_item_r <= s1_item_r;
    s2_prod_r <= prod_nxt;
  end

  always_comb begin
    sum_wide = {acc_r[ACC_W-1], acc_r} + {s2_prod_r[ACC_W-1], s2_prod_r};
    ovf_pos  = !sum_wide[ACC_W] && sum_wide[ACC_W-1];
    ovf_neg  = sum_wide[ACC_W] && !sum_wide[ACC_W-1];
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    bad_nxt  = bad_r || s2_item_r.bad;
    if (s2_item_r.add) begin
      if (ovf_pos) begin
        acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
        sat_nxt = 1'b1;
      end else if (ovf_neg) begin
        acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum_wide[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      sat_r     <= 1'b0;
      bad_r     <= 1'b0;
      row_ctr_r <= '0;
    end else if (s2_v_r) begin
      if (s2_item_r.close) begin
        acc_r     <= '0;
        sat_r     <= 1'b0;
        bad_r     <= 1'b0;
        row_ctr_r <= row_ctr_r + 1'b1;
      end else begin
        acc_r <= acc_nxt;
        sat_r <= sat_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  assign close_pending      = (s1_v_r && s1_item_r.close) || (s2_v_r && s2_item_r.close);
  assign close_valid        = s2_v_r && s2_item_r.close;
  assign close_info.acc     = acc_nxt;
  assign close_info.sat     = sat_nxt;
  assign close_info.bad     = bad_nxt;
  assign close_info.addend  = s2_item_r.addend;
  assign close_info.row_num = ROW_NUM_W'(row_ctr_r);

endmodule : spmv_mac
`default_nettype wire

// File: hw/rtl/spmv_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmv_finish
// Row epilogue: alpha*sum + beta*y + gamma on one shared 33x33 multiplier,
// clamp to Q16.16, and the result output register.
// ----------------------------------------------------------------------------
module spmv_finish
  import spmv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire row_close_t            info,
  input  wire logic [DATA_W-1:0]     alpha_gain,
  input  wire logic [DATA_W-1:0]     beta_gain,
  input  wire logic [DATA_W-1:0]     offset_term,
  output logic                       busy,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned MUL_W = DATA_W + 1;
  localparam int unsigned PRD_W = 2 * MUL_W;

  typedef enum logic [5:0] {
    FS_IDLE = 6'b000001,
    FS_BETA = 6'b000010,
    FS_LO   = 6'b000100,
    FS_HI   = 6'b001000,
    FS_ADD  = 6'b010000,
    FS_OUT  = 6'b100000
  } fin_state_t;

  fin_state_t              state_r, state_nxt;
  row_close_t              info_r;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [PRD_W-1:0] sum_r, sum_nxt, addend;
  logic                    fits;
  logic [DATA_W-1:0]       result;
  logic                    out_load;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      FS_BETA: begin
        mul_a = {beta_gain[DATA_W-1], beta_gain};
        mul_b = {info_r.addend[DATA_W-1], info_r.addend};
      end
      FS_LO: begin
        mul_a = {alpha_gain[DATA_W-1], alpha_gain};
        mul_b = {1'b0, info_r.acc[DATA_W-1:0]};
      end
      FS_HI: begin
        mul_a = {alpha_gain[DATA_W-1], alpha_gain};
        mul_b = {info_r.acc[ACC_W-1], info_r.acc[ACC_W-1:DATA_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    case (state_r)
      FS_LO:   addend = prod_r >>> 16;
      FS_HI:   addend = prod_r >>> 32;
      FS_ADD:  addend = prod_r;
      default: addend = '0;
    endcase
    if (start) begin
      sum_nxt = PRD_W'($signed(offset_term));
    end else begin
      sum_nxt = sum_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (start) begin
      info_r <= info;
    end
  end

  assign fits   = (&sum_r[PRD_W-1:DATA_W-1]) || !(|sum_r[PRD_W-1:DATA_W-1]);
  assign result = fits ? sum_r[DATA_W-1:0]
                : (sum_r[PRD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
  assign out_load = (state_r == FS_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: if (start) state_nxt = FS_BETA;
      FS_BETA: state_nxt = FS_LO;
      FS_LO:   state_nxt = FS_HI;
      FS_HI:   state_nxt = FS_ADD;
      FS_ADD:  state_nxt = FS_OUT;
      FS_OUT:  if (out_load) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - ROW_NUM_W - DATA_W - 2)'(0), info_r.bad,
                     info_r.sat || !fits, result, info_r.row_num};
    end
  end

  assign busy      = (state_r != FS_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : spmv_finish
`default_nettype wire

// File: hw/rtl/csr_sparse_matrix_vector_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Streamed CSR sparse matrix times dense vector: w = alpha*A*x + beta*y + gamma.
// ----------------------------------------------------------------------------
// Usage:
//   Load x with mode-0 transfers on the in_ channel, then stream the nonzeros
//   of A row by row as mode-1 transfers, in_tlast on the last nonzero of each
//   row; an empty row is one mode-2 transfer. in_tdata carries y for the row.
//   Each closed row gives one out_ transfer: row number, Q16.16 result and the
//   saturation and bad-column flags.
//   Loads and nonzeros inside a row are taken one per cycle while in_tready
//   is high; each column costs one vector store read and one 32x32
//   multiply-accumulate in a three-stage pipeline. A row-closing transfer
//   drops in_tready while the row passes the s1 and s2 accumulate pipeline
//   registers and a 5-step epilogue that runs alpha*sum (two partial
//   products) and beta*y through one shared multiplier.
//   When out_tready stays low, the result holds in the output register and
//   in_tready stays low after the next row closes until the slot frees.
//   Synchronous reset clears the pipeline, row accumulator, flags, row counter
//   and registers to alpha=1.0, beta=0, gamma=0, index base 0; the vector
//   store is not cleared and must be loaded before use.
//   cfg_ writes go straight into the registers; write only while the block is idle.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply
  import spmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH   = VECTOR_DEPTH_DEF,
  parameter int unsigned ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // index[12:0], value, addend_value
  input  wire logic                  in_tlast,   // row_end
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // row_number, row_result, saturated,
                                                 // bad_column
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH);
  localparam logic [31:0] DEPTH32 = 32'(VECTOR_DEPTH);

  logic [DATA_W-1:0] alpha_r, beta_r, offset_r;
  logic              base_r;

  logic [INDEX_W-1:0] in_index;
  logic [DATA_W-1:0]  in_value, in_addend;
  logic [31:0]        idx_ext, col;
  logic               accept, is_load, is_nz, is_empty, col_bad, load_ok;

  logic              mem_wr_en, mem_rd_en;
  logic [DATA_W-1:0] vec_data;

  nz_item_t   item;
  logic       item_valid;
  logic       close_pending, close_valid, fin_busy;
  row_close_t close_info;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 32'h0001_0000;
      beta_r   <= '0;
      offset_r <= '0;
      base_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALPHA:  alpha_r  <= cfg_wdata;
        REG_BETA:   beta_r   <= cfg_wdata;
        REG_OFFSET: offset_r <= cfg_wdata;
        REG_BASE:   base_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  assign in_index  = in_tdata[INDEX_W-1:0];
  assign in_value  = in_tdata[INDEX_W +: DATA_W];
  assign in_addend = in_tdata[INDEX_W+DATA_W +: DATA_W];

  assign in_tready = !(close_pending || fin_busy);
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == MODE_LOAD);
  assign is_nz     = (in_tuser == MODE_NONZERO);
  assign is_empty  = (in_tuser == MODE_EMPTY);

  assign idx_ext = 32'(in_index);
  assign col     = idx_ext - 32'(base_r);
  assign col_bad = (idx_ext < 32'(base_r)) || (col >= DEPTH32);
  assign load_ok = idx_ext < DEPTH32;

  assign mem_wr_en = accept && is_load && load_ok;
  assign mem_rd_en = accept && is_nz && !col_bad;

  assign item_valid   = accept && (is_nz || is_empty);
  assign item.add     = is_nz && !col_bad;
  assign item.bad     = is_nz && col_bad;
  assign item.close   = is_empty || (is_nz && in_tlast);
  assign item.value   = in_value;
  assign item.addend  = in_addend;

  spmv_vec_mem #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_vec_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (ADDR_W'(idx_ext)),
    .wr_data (in_value),
    .rd_en   (mem_rd_en),
    .rd_addr (ADDR_W'(col)),
    .rd_data (vec_data)
  );

  spmv_mac #(
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .vec_data      (vec_data),
    .close_pending (close_pending),
    .close_valid   (close_valid),
    .close_info    (close_info)
  );

  spmv_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (close_valid),
    .info        (close_info),
    .alpha_gain  (alpha_r),
    .beta_gain   (beta_r),
    .offset_term (offset_r),
    .busy        (fin_busy),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule : csr_sparse_matrix_vector_multiply
`default_nettype wire

// File: hw/rtl/spmv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmv_checker
// Port-level checks of the sparse matrix-vector engine, bound to the top level.
// ----------------------------------------------------------------------------
module spmv_checker
  import spmv_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  in_tlast,
  input wire logic [MODE_W-1:0]     in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == MODE_EMPTY || (in_tuser == MODE_NONZERO && in_tlast)) |=> !in_tready)
    else $error("input taken right after a row-closing transfer");

  a_result_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a row in the epilogue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

endmodule : spmv_checker

bind csr_sparse_matrix_vector_multiply spmv_checker u_spmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: tb/csr_sparse_matrix_vector_multiply_tb.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_tb
// Streams vector loads, CSR nonzeros and empty rows into the engine and checks
// every row result against a bit-true Q16.16 predictor kept in a scoreboard.
// Runs directed corner rows, then random phases under several gain and index
// base settings, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spmv_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_WAIT     = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 190;

  class row_scoreboard;
    typedef struct {
      logic [ROW_NUM_W-1:0] row;
      logic [DATA_W-1:0]    result;
      logic                 sat;
      logic                 bad;
    } row_out_t;

    logic [DATA_W-1:0]    alpha, beta, gamma;
    logic                 base;
    logic [DATA_W-1:0]    x_store [VECTOR_DEPTH_DEF];
    longint               acc;
    logic [ROW_NUM_W-1:0] row_cnt;
    bit                   sat_flag, bad_flag;
    row_out_t             expected_rows [$];
    int                   errors, rows_checked;

    function new();
      alpha = 32'h0001_0000;
      beta = '0;
      gamma = '0;
      base = 1'b0;
      acc = 0;
      row_cnt = '0;
      sat_flag = 1'b0;
      bad_flag = 1'b0;
      errors = 0;
      rows_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] addr, logic [DATA_W-1:0] data);
      case (addr)
        REG_ALPHA:  alpha = data;
        REG_BETA:   beta = data;
        REG_OFFSET: gamma = data;
        REG_BASE:   base = data[0];
        default: ;
      endcase
    endfunction

    function void add_product(longint p);
      logic signed [ACC_W:0] s;
      s = $signed({acc[63], acc}) + $signed({p[63], p});
      if (s[ACC_W] != s[ACC_W-1]) begin
        acc = s[ACC_W] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        sat_flag = 1'b1;
      end else begin
        acc = s[ACC_W-1:0];
      end
    endfunction

    function void close_row(logic [DATA_W-1:0] y);
      logic signed [95:0] a_wide, acc_wide, scaled;
      longint             t1, t2, by;
      logic signed [65:0] total;
      row_out_t           r;
      a_wide = $signed(alpha);
      acc_wide = acc;
      scaled = a_wide * acc_wide;
      t1 = scaled[95:32];
      by = longint'($signed(beta)) * longint'($signed(y));
      t2 = by >>> 16;
      total = t1 + t2 + $signed(gamma);
      r.sat = sat_flag;
      if (total > 66'sd2147483647) begin
        r.result = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else if (total < -66'sd2147483648) begin
        r.result = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.result = total[31:0];
      end
      r.row = row_cnt;
      r.bad = bad_flag;
      expected_rows.push_back(r);
      row_cnt = row_cnt + 1'b1;
      acc = 0;
      sat_flag = 1'b0;
      bad_flag = 1'b0;
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                             logic [DATA_W-1:0] val, logic last, logic [DATA_W-1:0] y);
      case (mode)
        MODE_LOAD: begin
          if (idx < VECTOR_DEPTH_DEF) x_store[idx] = val;
        end
        MODE_NONZERO: begin
          if (idx < base || idx - base >= VECTOR_DEPTH_DEF) begin
            bad_flag = 1'b1;
          end else begin
            add_product(longint'($signed(val)) * longint'($signed(x_store[idx - base])));
          end
          if (last) close_row(y);
        end
        MODE_EMPTY: close_row(y);
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      row_out_t e;
      if (expected_rows.size() == 0) begin
        $error("result for row %0d arrived with no row pending", d[15:0]);
        errors++;
        return;
      end
      e = expected_rows.pop_front();
      rows_checked++;
      if (d[15:0] !== e.row) begin
        $error("row_number expected %0d actual %0d", e.row, d[15:0]);
        errors++;
      end
      if (d[47:16] !== e.result) begin
        $error("row_result expected %0d actual %0d", $signed(e.result), $signed(d[47:16]));
        errors++;
      end
      if (d[48] !== e.sat) begin
        $error("saturated expected %0d actual %0d", e.sat, d[48]);
        errors++;
      end
      if (d[49] !== e.bad) begin
        $error("bad_column expected %0d actual %0d", e.bad, d[49]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // index[12:0], value, addend_value
  logic                  in_tlast;   // row_end
  logic [MODE_W-1:0]     in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // row_number, row_result, saturated, bad_column
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  row_scoreboard sb;
  bit            loaded [VECTOR_DEPTH_DEF];
  int            loaded_cols [$];
  logic          cur_base;
  bit            steady;
  bit            hold_req;
  bit            hold_done;
  int            items_sent;
  int            settings_applied;
  int            idle_cycles;

  csr_sparse_matrix_vector_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitors and stall watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_input(in_tuser, in_tdata[12:0], in_tdata[44:13], in_tlast, in_tdata[76:45]);
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result receiver: random back-pressure, one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0001_0000;
      default: return $urandom_range(2097152) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(5))
      0: return 32'h0001_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return $urandom_range(524288) - 32'd262144;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] good_index();
    int col;
    col = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    return INDEX_W'(col + cur_base);
  endfunction

  function automatic logic [INDEX_W-1:0] bad_index();
    return cur_base ? 13'd0 : 13'd4096;
  endfunction

  task automatic push_item(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                           logic [DATA_W-1:0] val, logic last, logic [DATA_W-1:0] y);
    if (!steady && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= last;
    in_tdata  <= {3'b000, y, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode != MODE_UNUSED && !(mode == MODE_LOAD && idx >= VECTOR_DEPTH_DEF)) begin
      items_sent++;
    end
  endtask

  task automatic load_entry(int pos, logic [DATA_W-1:0] v);
    push_item(MODE_LOAD, INDEX_W'(pos), v, 1'($urandom_range(1)), $urandom());
    if (pos < VECTOR_DEPTH_DEF && !loaded[pos]) begin
      loaded[pos] = 1'b1;
      loaded_cols.push_back(pos);
    end
  endtask

  task automatic empty_row(logic [DATA_W-1:0] y);
    push_item(MODE_EMPTY, INDEX_W'($urandom_range(4096)), $urandom(),
              1'($urandom_range(1)), y);
  endtask

  task automatic nonzero_row(int n, int bad_pct, bit closing);
    for (int i = 0; i < n; i++) begin
      push_item(MODE_NONZERO, ($urandom_range(99) < bad_pct) ? bad_index() : good_index(),
                rand_value(), closing && (i == n - 1), $urandom());
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  task automatic set_config(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                            logic [DATA_W-1:0] g, logic base);
    wait_idle();
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    write_reg(REG_OFFSET, g);
    write_reg(REG_BASE, {31'd0, base});
    cfg_we <= 1'b0;
    cur_base = base;
    settings_applied++;
  endtask

  initial begin
    int phase_start;
    int pick;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = MODE_LOAD;
    cfg_we = 1'b0;
    cfg_addr = REG_ALPHA;
    cfg_wdata = '0;
    cur_base = 1'b0;
    steady = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    items_sent = 0;
    settings_applied = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    load_entry(0, 32'h7FFF_FFFF);
    load_entry(1, 32'h8000_0000);
    load_entry(2, 32'hFFFF_0000);
    load_entry(4095, 32'h0001_0000);
    load_entry(3, $urandom());
    load_entry(4096, 32'hFFFF_FFFF);
    set_config(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    push_item(MODE_NONZERO, 13'd1, 32'h8000_0000, 1'b0, $urandom());
    push_item(MODE_NONZERO, 13'd1, 32'h8000_0000, 1'b1, $urandom());
    push_item(MODE_NONZERO, 13'd0, 32'h7FFF_FFFF, 1'b0, $urandom());
    push_item(MODE_NONZERO, 13'd4096, 32'h0000_0001, 1'b1, $urandom());
    empty_row(32'h7FFF_FFFF);
    push_item(MODE_NONZERO, 13'd4095, 32'h0001_0000, 1'b1, 32'h0);
    push_item(MODE_UNUSED, 13'd5, $urandom(), 1'b1, $urandom());
    push_item(MODE_NONZERO, 13'd2, 32'h0003_8000, 1'b0, $urandom());
    empty_row(32'h0002_0000);
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_item(MODE_NONZERO, 13'd0, 32'h7FFF_FFFF, 1'b0, $urandom());
    push_item(MODE_NONZERO, 13'd4096, 32'h8000_0000, 1'b0, $urandom());
    push_item(MODE_NONZERO, 13'd1, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    empty_row(32'h7FFF_FFFF);
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_item(MODE_NONZERO, 13'd1, 32'h8000_0000, 1'b0, $urandom());
    push_item(MODE_NONZERO, 13'd0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
    empty_row(32'h8000_0000);
    push_item(MODE_NONZERO, 13'd3, 32'h0, 1'b1, 32'h0);

    // random phases
    repeat (48) load_entry($urandom_range(4095), rand_value());
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(rand_gain(), rand_gain(), rand_gain(), 1'($urandom_range(1)));
      if (p == 1) hold_req <= 1'b1;
      steady <= (p == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          repeat ($urandom_range(4, 1)) load_entry($urandom_range(4095), rand_value());
        end else if (pick < 11) begin
          push_item(MODE_UNUSED, INDEX_W'($urandom_range(4096)), $urandom(),
                    1'($urandom_range(1)), $urandom());
        end else if (pick < 13) begin
          load_entry(4096, $urandom());
        end else if (pick < 17) begin
          nonzero_row($urandom_range(3, 1), 5, 1'b0);
          empty_row($urandom());
        end else if (pick < 27) begin
          empty_row(rand_value());
        end else begin
          nonzero_row($urandom_range(6, 1), 5, 1'b1);
        end
      end
    end
    steady <= 1'b0;

    wait_idle();
    $display("Streamed %0d items over %0d gain settings; %0d row results compared.",
             items_sent, settings_applied, sb.rows_checked);
    $display("Included saturation, bad columns, both index bases and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : csr_sparse_matrix_vector_multiply_tb
